// ===== src/klt_pkg.sv =====
// shared constants, types and codes for the keyed record list table
`default_nettype none
package klt_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int PTR_W   = $clog2(DEPTH + 1);
    localparam int CMD_W   = 3;
    localparam int KEY_W   = 32;
    localparam int YEAR_W  = 16;
    localparam int SCORE_W = 32;
    localparam int NAME_W  = 32;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = 5;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(DEPTH);

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [YEAR_W-1:0]       year;
        logic [SCORE_W-1:0]      score;
        logic [NAME_W-1:0]       name;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FREE,
        S_WALK,
        S_UNLINK
    } t_state;

endpackage
`default_nettype wire

// ===== src/klt_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
`default_nettype none
module klt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== src/klt_ctrl.sv =====
// command sequencer: list walk, slot allocation, link rewrites and result register
`default_nettype none
module klt_ctrl (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [klt_pkg::CMD_W-1:0]         i_command,
    input  wire logic signed [klt_pkg::KEY_W-1:0]  i_record_key,
    input  wire logic signed [klt_pkg::KEY_W-1:0]  i_replacement_key,
    input  wire logic [klt_pkg::YEAR_W-1:0]        i_year_value,
    input  wire logic [klt_pkg::SCORE_W-1:0]       i_score_bits,
    input  wire logic [klt_pkg::NAME_W-1:0]        i_name_handle,
    output klt_pkg::t_mem_req                      o_rec_req,
    output klt_pkg::t_rec                          o_rec_wdata,
    input  wire klt_pkg::t_rec                     i_rec_rdata,
    output klt_pkg::t_mem_req                      o_link_req,
    output logic [klt_pkg::PTR_W-1:0]              o_link_wdata,
    input  wire logic [klt_pkg::PTR_W-1:0]         i_link_rdata,
    output logic                                   o_valid,
    output logic [klt_pkg::STAT_W-1:0]             o_status,
    output klt_pkg::t_rec                          o_found,
    output logic [klt_pkg::ENTRY_W-1:0]            o_entry_count
);
    import klt_pkg::*;

    t_state                   r_state, n_state;
    logic [PTR_W-1:0]         r_head, n_head;
    logic [PTR_W-1:0]         r_free, n_free;
    logic [PTR_W-1:0]         r_fresh, n_fresh;
    logic [PTR_W-1:0]         r_count, n_count;
    logic [CMD_W-1:0]         r_cmd, n_cmd;
    t_rec                     r_rec, n_rec;
    logic signed [KEY_W-1:0]  r_newkey, n_newkey;
    logic [IDX_W-1:0]         r_cur, n_cur;
    logic [PTR_W-1:0]         r_prev, n_prev;
    logic [IDX_W-1:0]         r_steps, n_steps;
    logic                     r_valid, n_valid;
    logic [STAT_W-1:0]        r_status, n_status;
    t_rec                     r_found, n_found;
    logic [ENTRY_W-1:0]       r_entry, n_entry;

    logic in_search;
    logic walk_match;
    logic walk_more;
    t_rec in_rec;

    assign in_search  = (i_command == CMD_REMOVE) || (i_command == CMD_LOOKUP)
                     || (i_command == CMD_UPDATE);
    assign walk_match = (i_rec_rdata.key == r_rec.key);
    assign walk_more  = (i_link_rdata < NIL) && (r_steps != IDX_W'(DEPTH - 1));
    assign in_rec     = '{key: i_record_key, year: i_year_value,
                          score: i_score_bits, name: i_name_handle};

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_entry_count = r_entry;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_command == CMD_INSERT && r_count < NIL && r_free < NIL) begin
                        n_state = S_FREE;
                    end else if (in_search && r_head < NIL) begin
                        n_state = S_WALK;
                    end
                end
            end
            S_FREE: n_state = S_IDLE;
            S_WALK: begin
                if (walk_match) begin
                    n_state = (r_cmd == CMD_REMOVE) ? S_UNLINK : S_IDLE;
                end else if (!walk_more) begin
                    n_state = S_IDLE;
                end
            end
            S_UNLINK: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath, memory requests and result
    always_comb begin
        n_head       = r_head;
        n_free       = r_free;
        n_fresh      = r_fresh;
        n_count      = r_count;
        n_cmd        = r_cmd;
        n_rec        = r_rec;
        n_newkey     = r_newkey;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_steps      = r_steps;
        n_valid      = 1'b0;
        n_status     = r_status;
        n_found      = r_found;
        n_entry      = r_entry;
        o_rec_req    = '{we: 1'b0, waddr: r_cur, raddr: r_head[IDX_W-1:0]};
        o_rec_wdata  = r_rec;
        o_link_req   = '{we: 1'b0, waddr: r_cur, raddr: r_head[IDX_W-1:0]};
        o_link_wdata = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd    = i_command;
                    n_rec    = in_rec;
                    n_newkey = i_replacement_key;
                    n_cur    = r_head[IDX_W-1:0];
                    n_prev   = NIL;
                    n_steps  = '0;
                    priority if (i_command == CMD_INSERT) begin
                        priority if (r_count >= NIL) begin
                            n_valid  = 1'b1;
                            n_status = ST_FULL;
                            n_found  = '0;
                        end else if (r_free < NIL) begin
                            // reuse a freed slot: fetch its link first
                            o_link_req.raddr = r_free[IDX_W-1:0];
                        end else if (r_fresh < NIL) begin
                            o_rec_req.we       = 1'b1;
                            o_rec_req.waddr    = r_fresh[IDX_W-1:0];
                            o_rec_wdata        = in_rec;
                            o_link_req.we      = 1'b1;
                            o_link_req.waddr   = r_fresh[IDX_W-1:0];
                            o_link_wdata       = r_head;
                            n_head             = r_fresh;
                            n_fresh            = r_fresh + 1'b1;
                            n_count            = r_count + 1'b1;
                            n_valid            = 1'b1;
                            n_status           = ST_OK;
                            n_found            = in_rec;
                        end else begin
                            n_valid  = 1'b1;
                            n_status = ST_FULL;
                            n_found  = '0;
                        end
                    end else if (in_search) begin
                        if (r_head >= NIL) begin
                            n_valid  = 1'b1;
                            n_status = ST_EMPTY;
                            n_found  = '0;
                        end
                    end else if (i_command == CMD_CLEAR) begin
                        n_head   = NIL;
                        n_free   = NIL;
                        n_fresh  = '0;
                        n_count  = '0;
                        n_valid  = 1'b1;
                        n_status = ST_OK;
                        n_found  = '0;
                    end else begin
                        n_valid  = 1'b1;
                        n_status = ST_OK;
                        n_found  = '0;
                    end
                end
            end
            S_FREE: begin
                o_rec_req.we     = 1'b1;
                o_rec_req.waddr  = r_free[IDX_W-1:0];
                o_rec_wdata      = r_rec;
                o_link_req.we    = 1'b1;
                o_link_req.waddr = r_free[IDX_W-1:0];
                o_link_wdata     = r_head;
                n_free           = i_link_rdata;
                n_head           = r_free;
                n_count          = r_count + 1'b1;
                n_valid          = 1'b1;
                n_status         = ST_OK;
                n_found          = r_rec;
            end
            S_WALK: begin
                if (walk_match) begin
                    n_found  = i_rec_rdata;
                    n_status = ST_OK;
                    if (r_cmd == CMD_REMOVE) begin
                        // bypass the matched entry
                        if (r_prev < NIL) begin
                            o_link_req.we    = 1'b1;
                            o_link_req.waddr = r_prev[IDX_W-1:0];
                            o_link_wdata     = i_link_rdata;
                        end else begin
                            n_head = i_link_rdata;
                        end
                    end else begin
                        n_valid = 1'b1;
                        if (r_cmd == CMD_UPDATE) begin
                            o_rec_req.we    = 1'b1;
                            o_rec_req.waddr = r_cur;
                            o_rec_wdata     = '{key: r_newkey, year: r_rec.year,
                                                score: r_rec.score, name: r_rec.name};
                        end
                    end
                end else if (walk_more) begin
                    o_rec_req.raddr  = i_link_rdata[IDX_W-1:0];
                    o_link_req.raddr = i_link_rdata[IDX_W-1:0];
                    n_prev           = PTR_W'(r_cur);
                    n_cur            = i_link_rdata[IDX_W-1:0];
                    n_steps          = r_steps + 1'b1;
                end else begin
                    n_valid  = 1'b1;
                    n_status = ST_NOT_FOUND;
                    n_found  = '0;
                end
            end
            S_UNLINK: begin
                // removed slot goes on top of the free list
                o_link_req.we    = 1'b1;
                o_link_req.waddr = r_cur;
                o_link_wdata     = r_free;
                n_free           = PTR_W'(r_cur);
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
                n_valid = 1'b1;
            end
            default: ;
        endcase

        if (n_valid) begin
            n_entry = ENTRY_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NIL;
            r_free  <= NIL;
            r_fresh <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            r_fresh <= n_fresh;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_rec    <= n_rec;
        r_newkey <= n_newkey;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_steps  <= n_steps;
        r_status <= n_status;
        r_found  <= n_found;
        r_entry  <= n_entry;
    end

endmodule
`default_nettype wire

// ===== src/keyed_record_list_table_unit.sv =====
// insert into a never-used slot, clear, unused codes and full or empty results answer straight
// from idle; insert into a freed slot reads its link, then writes it; lookup, update and
// a missed key walk the list, one read per link on the record and link rams, 1..DEPTH links;
// a remove that hits adds an unlink step. one command at a time; the next start is taken in the
// cycle the result shows. results are strobed for one cycle and cannot be stalled.
// reset clears head, free list, fill count and valid; the entry count and rams are not cleared.
`default_nettype none
module keyed_record_list_table_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [klt_pkg::CMD_W-1:0]         i_command,
    input  wire logic signed [klt_pkg::KEY_W-1:0]  i_record_key,
    input  wire logic signed [klt_pkg::KEY_W-1:0]  i_replacement_key,
    input  wire logic [klt_pkg::YEAR_W-1:0]        i_year_value,
    input  wire logic [klt_pkg::SCORE_W-1:0]       i_score_bits,
    input  wire logic [klt_pkg::NAME_W-1:0]        i_name_handle,
    output logic                                   o_valid,
    output logic [klt_pkg::STAT_W-1:0]             o_status,
    output logic signed [klt_pkg::KEY_W-1:0]       o_found_key,
    output logic [klt_pkg::YEAR_W-1:0]             o_found_year,
    output logic [klt_pkg::SCORE_W-1:0]            o_found_score,
    output logic [klt_pkg::NAME_W-1:0]             o_found_name,
    output logic [klt_pkg::ENTRY_W-1:0]            o_entry_count
);
    import klt_pkg::*;

    t_mem_req         rec_req;
    t_mem_req         link_req;
    t_rec             rec_wdata;
    t_rec             rec_rdata;
    logic [REC_W-1:0] rec_rdata_bits;
    logic [PTR_W-1:0] link_wdata;
    logic [PTR_W-1:0] link_rdata;
    t_rec             found;

    assign rec_rdata = t_rec'(rec_rdata_bits);

    klt_ram #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_req.we),
        .i_waddr (rec_req.waddr),
        .i_wdata (REC_W'(rec_wdata)),
        .i_raddr (rec_req.raddr),
        .o_rdata (rec_rdata_bits)
    );

    klt_ram #(.WIDTH(PTR_W), .DEPTH(DEPTH)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_req.we),
        .i_waddr (link_req.waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_req.raddr),
        .o_rdata (link_rdata)
    );

    klt_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_command         (i_command),
        .i_record_key      (i_record_key),
        .i_replacement_key (i_replacement_key),
        .i_year_value      (i_year_value),
        .i_score_bits      (i_score_bits),
        .i_name_handle     (i_name_handle),
        .o_rec_req         (rec_req),
        .o_rec_wdata       (rec_wdata),
        .i_rec_rdata       (rec_rdata),
        .o_link_req        (link_req),
        .o_link_wdata      (link_wdata),
        .i_link_rdata      (link_rdata),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_found           (found),
        .o_entry_count     (o_entry_count)
    );

    assign o_found_key   = found.key;
    assign o_found_year  = found.year;
    assign o_found_score = found.score;
    assign o_found_name  = found.name;

endmodule
`default_nettype wire
